// File: hdl/rbsi_pkg.sv
// rbsi_pkg: shared types, widths and codes for the ray/box slab intersection block
// no dependencies; used by every module under hdl
package rbsi_pkg;

    localparam int FIX_W     = 32;
    localparam int SLAB_W    = 49;
    localparam int DIV_STEPS = 48;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    typedef logic signed [FIX_W-1:0]  fix_t;
    typedef logic signed [SLAB_W-1:0] slab_t;
    typedef fix_t [2:0]  vec3_t;
    typedef slab_t [2:0] slab3_t;

    typedef struct packed {
        vec3_t lo;
        vec3_t hi;
    } box_t;

    typedef enum logic [2:0] {
        REG_MIN_X,
        REG_MIN_Y,
        REG_MIN_Z,
        REG_MAX_X,
        REG_MAX_Y,
        REG_MAX_Z
    } reg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        slab_t t;
        axis_t ax;
        logic  ok;
    } cand_t;

    typedef struct packed {
        logic  hit;
        logic  outside;
        axis_t ax;
        logic  negn;
    } hit_info_t;

    // later axis wins on a strictly larger entry or when the earlier is invalid
    function automatic cand_t pick_near(cand_t a, cand_t b);
        cand_t r;
        if (!a.ok || (b.ok && ($signed(b.t) > $signed(a.t))))
            r = b;
        else
            r = a;
        return r;
    endfunction

    // later axis wins on a strictly smaller exit or when the earlier is invalid
    function automatic cand_t pick_far(cand_t a, cand_t b);
        cand_t r;
        if (!a.ok || (b.ok && ($signed(b.t) < $signed(a.t))))
            r = b;
        else
            r = a;
        return r;
    endfunction

endpackage

// File: hdl/ray_box_slab_intersection.sv
// ray_box_slab_intersection: top level of the ray versus axis-aligned box test
// depends on rbsi_pkg, rbsi_cfg, rbsi_slab, rbsi_div, rbsi_sel, rbsi_pt
//
// usage:
//   box corners are written over the apb port (min x,y,z then max x,y,z at
//   byte addresses 0..20), only while no ray is in flight
//   each ray request on the s_axis side (origin and direction, q16.16) gives
//   exactly one result request on the m_axis side, in order
//   the stages are one numerator stage, the divider pipeline
//   (one quotient bit per stage), four selection stages and four point stages
//   throughput is one ray per cycle; all stages move together, so a stalled
//   result holds the whole pipeline and s_axis_tready follows
//   m_axis_tready || !m_axis_tvalid
//   a miss returns a result with every field zero
//   reset clears the box registers to zero and empties the pipeline
module ray_box_slab_intersection
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [191:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // hit, from_outside, t_param, point_x, point_y, point_z, normal_axis,
    // normal_negative, zero pad
    output logic [135:0]  m_axis_tdata
);

    rbsi_pkg::box_t      box;
    logic                en;
    logic                slab_v, sel_v, pt_v;
    rbsi_pkg::slab3_t    t_lo, t_hi;
    rbsi_pkg::vec3_t     slab_o, slab_d, sel_o, sel_d, point;
    rbsi_pkg::hit_info_t sel_info, res_info;
    rbsi_pkg::slab_t     sel_t;
    rbsi_pkg::fix_t      t_param;

    assign en            = m_axis_tready || !pt_v;
    assign s_axis_tready = en;

    rbsi_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .box     (box)
    );

    rbsi_slab u_slab
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .o         (s_axis_tdata[95:0]),
        .d         (s_axis_tdata[191:96]),
        .box       (box),
        .out_valid (slab_v),
        .t_lo      (t_lo),
        .t_hi      (t_hi),
        .o_out     (slab_o),
        .d_out     (slab_d)
    );

    rbsi_sel u_sel
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (slab_v),
        .t_lo      (t_lo),
        .t_hi      (t_hi),
        .o         (slab_o),
        .d         (slab_d),
        .box       (box),
        .out_valid (sel_v),
        .info      (sel_info),
        .t         (sel_t),
        .o_out     (sel_o),
        .d_out     (sel_d)
    );

    rbsi_pt u_pt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sel_v),
        .info      (sel_info),
        .t         (sel_t),
        .o         (sel_o),
        .d         (sel_d),
        .out_valid (pt_v),
        .info_out  (res_info),
        .t_param   (t_param),
        .point     (point)
    );

    assign m_axis_tvalid = pt_v;
    assign m_axis_tdata  = {3'b0, res_info.negn, res_info.ax, point, t_param,
                            res_info.outside, res_info.hit};

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[132:1] == '0))
        else $error("miss result carries nonzero fields");

    a_entry_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[1])
            |-> ($signed(m_axis_tdata[33:2]) > 0))
        else $error("entry face reported with t not positive");

    a_exit_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0] && !m_axis_tdata[1])
            |-> ($signed(m_axis_tdata[33:2]) >= 0))
        else $error("exit face reported with negative t");

    a_axis_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[131:130] != 2'd3))
        else $error("normal axis out of range");

endmodule

// File: hdl/rbsi_cfg.sv
// rbsi_cfg: apb register file holding the box corners
// depends on rbsi_pkg
module rbsi_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output rbsi_pkg::box_t     box
);

    rbsi_pkg::box_t     box_reg;
    rbsi_pkg::box_t     box_next;
    rbsi_pkg::reg_idx_t idx;
    logic               wr;

    assign pready = 1'b1;
    assign idx    = rbsi_pkg::reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign box    = box_reg;

    always_comb
    begin
        box_next = box_reg;
        if (wr)
        begin
            unique case (idx)
                rbsi_pkg::REG_MIN_X: box_next.lo[0] = pwdata;
                rbsi_pkg::REG_MIN_Y: box_next.lo[1] = pwdata;
                rbsi_pkg::REG_MIN_Z: box_next.lo[2] = pwdata;
                rbsi_pkg::REG_MAX_X: box_next.hi[0] = pwdata;
                rbsi_pkg::REG_MAX_Y: box_next.hi[1] = pwdata;
                rbsi_pkg::REG_MAX_Z: box_next.hi[2] = pwdata;
                default:             box_next = box_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            rbsi_pkg::REG_MIN_X: prdata = box_reg.lo[0];
            rbsi_pkg::REG_MIN_Y: prdata = box_reg.lo[1];
            rbsi_pkg::REG_MIN_Z: prdata = box_reg.lo[2];
            rbsi_pkg::REG_MAX_X: prdata = box_reg.hi[0];
            rbsi_pkg::REG_MAX_Y: prdata = box_reg.hi[1];
            rbsi_pkg::REG_MAX_Z: prdata = box_reg.hi[2];
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_reg <= '0;
        else
            box_reg <= box_next;
    end

endmodule

// File: hdl/rbsi_div.sv
// rbsi_div: pipelined signed divider, one quotient bit per stage, truncates toward zero
// depends on rbsi_pkg
module rbsi_div
(
    input  logic                   clk,
    input  logic                   en,
    input  rbsi_pkg::slab_t        num,
    input  rbsi_pkg::fix_t         den,
    output rbsi_pkg::slab_t        quo
);

    localparam int N = rbsi_pkg::DIV_STEPS;
    localparam int W = rbsi_pkg::FIX_W;

    logic [N-1:0]    dq_reg  [0:N];
    logic [W-1:0]    rem_reg [0:N-1];
    logic [W-1:0]    dv_reg  [0:N-1];
    logic            neg_reg [0:N];
    rbsi_pkg::slab_t quo_reg;
    logic [rbsi_pkg::SLAB_W-1:0] num_abs;
    logic [W-1:0]    den_abs;

    assign num_abs = num[rbsi_pkg::SLAB_W-1] ? -num : num;
    assign den_abs = den[W-1] ? -den : den;
    assign quo     = quo_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dq_reg[0]  <= num_abs[N-1:0];
            rem_reg[0] <= '0;
            dv_reg[0]  <= den_abs;
            neg_reg[0] <= num[rbsi_pkg::SLAB_W-1] ^ den[W-1];
            quo_reg    <= neg_reg[N] ? -rbsi_pkg::slab_t'({1'b0, dq_reg[N]})
                                     :  rbsi_pkg::slab_t'({1'b0, dq_reg[N]});
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [W:0] sh;
        logic [W:0] diff;

        assign sh   = {rem_reg[k], dq_reg[k][N-1]};
        assign diff = sh - {1'b0, dv_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dq_reg[k+1]  <= {dq_reg[k][N-2:0], ~diff[W]};
                neg_reg[k+1] <= neg_reg[k];
            end
        end

        if (k < N - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= diff[W] ? sh[W-1:0] : diff[W-1:0];
                    dv_reg[k+1]  <= dv_reg[k];
                end
            end
        end
    end

endmodule

// File: hdl/rbsi_slab.sv
// rbsi_slab: slab numerators and six pipelined dividers giving per-axis slab parameters
// depends on rbsi_pkg and rbsi_div
module rbsi_slab
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  rbsi_pkg::vec3_t    o,
    input  rbsi_pkg::vec3_t    d,
    input  rbsi_pkg::box_t     box,
    output logic               out_valid,
    output rbsi_pkg::slab3_t   t_lo,
    output rbsi_pkg::slab3_t   t_hi,
    output rbsi_pkg::vec3_t    o_out,
    output rbsi_pkg::vec3_t    d_out
);

    localparam int L = rbsi_pkg::DIV_LAT;

    rbsi_pkg::slab3_t na_reg;
    rbsi_pkg::slab3_t nb_reg;
    rbsi_pkg::vec3_t  oa_reg;
    rbsi_pkg::vec3_t  da_reg;
    logic             va_reg;
    rbsi_pkg::vec3_t  o_dl_reg [0:L-1];
    rbsi_pkg::vec3_t  d_dl_reg [0:L-1];
    logic [L-1:0]     v_dl_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                na_reg[i] <= {({box.lo[i][31], box.lo[i]} - {o[i][31], o[i]}), 16'b0};
                nb_reg[i] <= {({box.hi[i][31], box.hi[i]} - {o[i][31], o[i]}), 16'b0};
            end
            oa_reg      <= o;
            da_reg      <= d;
            o_dl_reg[0] <= oa_reg;
            d_dl_reg[0] <= da_reg;
            for (int k = 1; k < L; k++)
            begin
                o_dl_reg[k] <= o_dl_reg[k-1];
                d_dl_reg[k] <= d_dl_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            v_dl_reg <= '0;
        end
        else if (en)
        begin
            va_reg   <= in_valid;
            v_dl_reg <= {v_dl_reg[L-2:0], va_reg};
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        rbsi_div u_div_lo
        (
            .clk (clk),
            .en  (en),
            .num (na_reg[i]),
            .den (da_reg[i]),
            .quo (t_lo[i])
        );
        rbsi_div u_div_hi
        (
            .clk (clk),
            .en  (en),
            .num (nb_reg[i]),
            .den (da_reg[i]),
            .quo (t_hi[i])
        );
    end

    assign out_valid = v_dl_reg[L-1];
    assign o_out     = o_dl_reg[L-1];
    assign d_out     = d_dl_reg[L-1];

endmodule

// File: hdl/rbsi_sel.sv
// rbsi_sel: orders slab parameters, reduces entry/exit over the axes, decides hit and face
// depends on rbsi_pkg
module rbsi_sel
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  rbsi_pkg::slab3_t     t_lo,
    input  rbsi_pkg::slab3_t     t_hi,
    input  rbsi_pkg::vec3_t      o,
    input  rbsi_pkg::vec3_t      d,
    input  rbsi_pkg::box_t       box,
    output logic                 out_valid,
    output rbsi_pkg::hit_info_t  info,
    output rbsi_pkg::slab_t      t,
    output rbsi_pkg::vec3_t      o_out,
    output rbsi_pkg::vec3_t      d_out
);

    // stage 1: ordered parameters and zero-direction checks
    rbsi_pkg::slab3_t s1_lo_reg, s1_hi_reg;
    logic [2:0]       s1_ok_reg;
    logic             s1_zm_reg, s1_v_reg;
    rbsi_pkg::vec3_t  s1_o_reg, s1_d_reg;
    // stage 2: axes x and y combined
    rbsi_pkg::cand_t  s2_near_reg, s2_far_reg;
    rbsi_pkg::slab_t  s2_lo_reg, s2_hi_reg;
    logic             s2_ok_reg, s2_zm_reg, s2_v_reg;
    rbsi_pkg::vec3_t  s2_o_reg, s2_d_reg;
    // stage 3: all axes combined
    rbsi_pkg::cand_t  s3_near_reg, s3_far_reg;
    logic             s3_zm_reg, s3_v_reg;
    rbsi_pkg::vec3_t  s3_o_reg, s3_d_reg;
    // stage 4: decision
    rbsi_pkg::hit_info_t s4_info_reg;
    rbsi_pkg::slab_t     s4_t_reg;
    logic                s4_v_reg;
    rbsi_pkg::vec3_t     s4_o_reg, s4_d_reg;

    rbsi_pkg::slab3_t    lo_c, hi_c;
    logic [2:0]          ok_c, zm_c;
    rbsi_pkg::cand_t     near01, far01, near_c, far_c;
    rbsi_pkg::hit_info_t info_c;
    rbsi_pkg::slab_t     t_c;
    logic                miss_c, dpos_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ok_c[i] = (d[i] != '0);
            zm_c[i] = !ok_c[i] && (($signed(o[i]) < $signed(box.lo[i]))
                                || ($signed(o[i]) > $signed(box.hi[i])));
            if ($signed(t_hi[i]) < $signed(t_lo[i]))
            begin
                lo_c[i] = t_hi[i];
                hi_c[i] = t_lo[i];
            end
            else
            begin
                lo_c[i] = t_lo[i];
                hi_c[i] = t_hi[i];
            end
        end
    end

    always_comb
    begin
        near01 = rbsi_pkg::pick_near('{s1_lo_reg[0], rbsi_pkg::AXIS_X, s1_ok_reg[0]},
                                     '{s1_lo_reg[1], rbsi_pkg::AXIS_Y, s1_ok_reg[1]});
        far01  = rbsi_pkg::pick_far('{s1_hi_reg[0], rbsi_pkg::AXIS_X, s1_ok_reg[0]},
                                    '{s1_hi_reg[1], rbsi_pkg::AXIS_Y, s1_ok_reg[1]});
        near_c = rbsi_pkg::pick_near(s2_near_reg, '{s2_lo_reg, rbsi_pkg::AXIS_Z, s2_ok_reg});
        far_c  = rbsi_pkg::pick_far(s2_far_reg, '{s2_hi_reg, rbsi_pkg::AXIS_Z, s2_ok_reg});
    end

    always_comb
    begin
        miss_c = s3_zm_reg || !s3_near_reg.ok
              || ($signed(s3_near_reg.t) > $signed(s3_far_reg.t))
              || ($signed(s3_far_reg.t) < 0);
        info_c.hit     = !miss_c;
        info_c.outside = $signed(s3_near_reg.t) > 0;
        if (info_c.outside)
        begin
            t_c       = s3_near_reg.t;
            info_c.ax = s3_near_reg.ax;
        end
        else
        begin
            t_c       = s3_far_reg.t;
            info_c.ax = s3_far_reg.ax;
        end
        dpos_c      = $signed(s3_d_reg[info_c.ax]) > 0;
        info_c.negn = info_c.outside ? dpos_c : !dpos_c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_lo_reg   <= lo_c;
            s1_hi_reg   <= hi_c;
            s1_ok_reg   <= ok_c;
            s1_zm_reg   <= |zm_c;
            s1_o_reg    <= o;
            s1_d_reg    <= d;
            s2_near_reg <= near01;
            s2_far_reg  <= far01;
            s2_lo_reg   <= s1_lo_reg[2];
            s2_hi_reg   <= s1_hi_reg[2];
            s2_ok_reg   <= s1_ok_reg[2];
            s2_zm_reg   <= s1_zm_reg;
            s2_o_reg    <= s1_o_reg;
            s2_d_reg    <= s1_d_reg;
            s3_near_reg <= near_c;
            s3_far_reg  <= far_c;
            s3_zm_reg   <= s2_zm_reg;
            s3_o_reg    <= s2_o_reg;
            s3_d_reg    <= s2_d_reg;
            s4_info_reg <= info_c;
            s4_t_reg    <= t_c;
            s4_o_reg    <= s3_o_reg;
            s4_d_reg    <= s3_d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    assign out_valid = s4_v_reg;
    assign info      = s4_info_reg;
    assign t         = s4_t_reg;
    assign o_out     = s4_o_reg;
    assign d_out     = s4_d_reg;

endmodule

// File: hdl/rbsi_pt.sv
// rbsi_pt: hit point as origin plus direction times t, saturated, and the result register
// depends on rbsi_pkg
module rbsi_pt
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  rbsi_pkg::hit_info_t  info,
    input  rbsi_pkg::slab_t      t,
    input  rbsi_pkg::vec3_t      o,
    input  rbsi_pkg::vec3_t      d,
    output logic                 out_valid,
    output rbsi_pkg::hit_info_t  info_out,
    output rbsi_pkg::fix_t       t_param,
    output rbsi_pkg::vec3_t      point
);

    localparam logic signed [rbsi_pkg::SLAB_W-1:0] T_MAX = 49'sd2147483647;
    localparam logic signed [rbsi_pkg::SLAB_W-1:0] T_MIN = -49'sd2147483648;
    localparam logic [64:0] MAG_CAP = 65'd17179869184;
    localparam logic signed [36:0] P_MAX = 37'sd2147483647;
    localparam logic signed [36:0] P_MIN = -37'sd2147483648;

    // stage 1
    rbsi_pkg::hit_info_t p1_info_reg;
    rbsi_pkg::fix_t      p1_t_reg;
    logic [31:0]         p1_ad_reg [0:2];
    logic [2:0]          p1_neg_reg;
    logic [31:0]         p1_ahi_reg;
    logic [15:0]         p1_alo_reg;
    rbsi_pkg::vec3_t     p1_o_reg;
    logic                p1_v_reg;
    // stage 2
    rbsi_pkg::hit_info_t p2_info_reg;
    rbsi_pkg::fix_t      p2_t_reg;
    logic [63:0]         p2_hi_reg [0:2];
    logic [47:0]         p2_lo_reg [0:2];
    logic [2:0]          p2_neg_reg;
    rbsi_pkg::vec3_t     p2_o_reg;
    logic                p2_v_reg;
    // stage 3
    rbsi_pkg::hit_info_t p3_info_reg;
    rbsi_pkg::fix_t      p3_t_reg;
    logic [34:0]         p3_mag_reg [0:2];
    logic [2:0]          p3_neg_reg;
    rbsi_pkg::vec3_t     p3_o_reg;
    logic                p3_v_reg;
    // result
    rbsi_pkg::hit_info_t r_info_reg;
    rbsi_pkg::fix_t      r_t_reg;
    rbsi_pkg::vec3_t     r_pt_reg;
    logic                r_v_reg;

    rbsi_pkg::fix_t      tsat_c;
    logic [64:0]         sum_c [0:2];
    logic signed [36:0]  pt_c  [0:2];
    rbsi_pkg::vec3_t     ptsat_c;

    always_comb
    begin
        if ($signed(t) > T_MAX)
            tsat_c = T_MAX[31:0];
        else if ($signed(t) < T_MIN)
            tsat_c = T_MIN[31:0];
        else
            tsat_c = t[31:0];
        for (int i = 0; i < 3; i++)
        begin
            sum_c[i] = {1'b0, p2_hi_reg[i]} + {33'b0, p2_lo_reg[i][47:16]};
            pt_c[i]  = p3_neg_reg[i]
                     ? {{5{p3_o_reg[i][31]}}, p3_o_reg[i]} - {2'b0, p3_mag_reg[i]}
                     : {{5{p3_o_reg[i][31]}}, p3_o_reg[i]} + {2'b0, p3_mag_reg[i]};
            if (pt_c[i] > P_MAX)
                ptsat_c[i] = P_MAX[31:0];
            else if (pt_c[i] < P_MIN)
                ptsat_c[i] = P_MIN[31:0];
            else
                ptsat_c[i] = pt_c[i][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_info_reg <= info;
            p1_t_reg    <= tsat_c;
            p1_ahi_reg  <= t[47:16];
            p1_alo_reg  <= t[15:0];
            p1_o_reg    <= o;
            for (int i = 0; i < 3; i++)
            begin
                p1_ad_reg[i]  <= d[i][31] ? -d[i] : d[i];
                p1_neg_reg[i] <= d[i][31];
            end
            p2_info_reg <= p1_info_reg;
            p2_t_reg    <= p1_t_reg;
            p2_neg_reg  <= p1_neg_reg;
            p2_o_reg    <= p1_o_reg;
            for (int i = 0; i < 3; i++)
            begin
                p2_hi_reg[i] <= 64'(p1_ad_reg[i]) * 64'(p1_ahi_reg);
                p2_lo_reg[i] <= 48'(p1_ad_reg[i]) * 48'(p1_alo_reg);
            end
            p3_info_reg <= p2_info_reg;
            p3_t_reg    <= p2_t_reg;
            p3_neg_reg  <= p2_neg_reg;
            p3_o_reg    <= p2_o_reg;
            for (int i = 0; i < 3; i++)
                p3_mag_reg[i] <= (sum_c[i] > MAG_CAP) ? MAG_CAP[34:0] : sum_c[i][34:0];
            if (p3_info_reg.hit)
            begin
                r_info_reg <= p3_info_reg;
                r_t_reg    <= p3_t_reg;
                r_pt_reg   <= ptsat_c;
            end
            else
            begin
                r_info_reg <= '0;
                r_t_reg    <= '0;
                r_pt_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            r_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg <= in_valid;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            r_v_reg  <= p3_v_reg;
        end
    end

    assign out_valid = r_v_reg;
    assign info_out  = r_info_reg;
    assign t_param   = r_t_reg;
    assign point     = r_pt_reg;

endmodule
